@@ rtl/adrc_pkg.sv @@
// shared types, constants and helpers for the axis dead-zone ramp conditioner
package adrc_pkg;

   localparam int AXIS_W  = 16;
   localparam int SPEED_W = 16;
   localparam int STEP_W  = 15;
   localparam int WIDE_W  = 18;
   localparam int GAIN_W  = 16;
   localparam int SHIFT_W = 16;
   localparam int PROD_W  = 2 * (AXIS_W + 1);

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // register indexes on the csr channel
   localparam logic [CSR_IDX_W-1:0] REG_AXIS_ENABLED  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_AXIS_CENTER   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DEAD_HALF     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_INVERT_AXIS   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_JOYSTICK_GAIN = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_ACCELERATION  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_DECELERATION  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_SPEED     = 3'd7;

   // register reset values
   localparam logic [AXIS_W-1:0] RST_AXIS_CENTER   = 16'd32768;
   localparam logic [AXIS_W-1:0] RST_DEAD_HALF     = 16'd1638;
   localparam logic [GAIN_W-1:0] RST_JOYSTICK_GAIN = 16'd4096;
   localparam logic [STEP_W-1:0] RST_ACCELERATION  = 15'd41;
   localparam logic [STEP_W-1:0] RST_DECELERATION  = 15'd41;
   localparam logic [STEP_W-1:0] RST_MAX_SPEED     = 15'd4096;

   // 0.01 in q4.12, the snap-to-zero window
   localparam logic signed [WIDE_W-1:0] SNAP_LIMIT = 18'sd41;
   localparam logic signed [WIDE_W-1:0] SPEED_HI   = 18'sd32767;
   localparam logic signed [WIDE_W-1:0] SPEED_LO   = -18'sd32768;

   typedef struct packed {
      logic              axis_enabled;
      logic [AXIS_W-1:0] axis_center;
      logic [AXIS_W-1:0] dead_half;
      logic              invert_axis;
      logic [GAIN_W-1:0] joystick_gain;
      logic [STEP_W-1:0] acceleration;
      logic [STEP_W-1:0] deceleration;
      logic [STEP_W-1:0] max_speed;
   } cfg_type;

   function automatic logic signed [SPEED_W-1:0] sat_speed(input logic signed [WIDE_W-1:0] v);
      logic signed [SPEED_W-1:0] r;
      if (v > SPEED_HI) begin
         r = SPEED_HI[SPEED_W-1:0];
      end else if (v < SPEED_LO) begin
         r = SPEED_LO[SPEED_W-1:0];
      end else begin
         r = v[SPEED_W-1:0];
      end
      return r;
   endfunction

endpackage

@@ rtl/adrc_channels.sv @@
// valid/ready channel interfaces: sample items, speed items, register writes
interface adrc_req_if;
   logic                          valid;
   logic                          ready;
   logic [adrc_pkg::AXIS_W-1:0]   raw_axis;
   logic                          key_up;
   logic                          key_down;

   modport source(output valid, raw_axis, key_up, key_down, input ready);
   modport sink(input valid, raw_axis, key_up, key_down, output ready);
endinterface

interface adrc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [adrc_pkg::SPEED_W-1:0]  speed;
   logic                          joystick_active;

   modport source(output valid, speed, joystick_active, input ready);
   modport sink(input valid, speed, joystick_active, output ready);
endinterface

interface adrc_csr_if;
   logic                            valid;
   logic                            ready;
   logic [adrc_pkg::CSR_IDX_W-1:0]  index;
   logic [adrc_pkg::CSR_DATA_W-1:0] data;

   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

@@ rtl/adrc_csr_regs.sv @@
// configuration register file written over the csr channel
module adrc_csr_regs (
   input  logic              clock,
   input  logic              reset,
   adrc_csr_if.sink          csr_bus,
   output adrc_pkg::cfg_type cfg
);
   import adrc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_en;

   assign csr_bus.ready = 1'b1;
   assign wr_en         = csr_bus.valid;
   assign cfg           = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (csr_bus.index)
            REG_AXIS_ENABLED:  cfg_in.axis_enabled  = csr_bus.data[0];
            REG_AXIS_CENTER:   cfg_in.axis_center   = csr_bus.data[AXIS_W-1:0];
            REG_DEAD_HALF:     cfg_in.dead_half     = csr_bus.data[AXIS_W-1:0];
            REG_INVERT_AXIS:   cfg_in.invert_axis   = csr_bus.data[0];
            REG_JOYSTICK_GAIN: cfg_in.joystick_gain = csr_bus.data[GAIN_W-1:0];
            REG_ACCELERATION:  cfg_in.acceleration  = csr_bus.data[STEP_W-1:0];
            REG_DECELERATION:  cfg_in.deceleration  = csr_bus.data[STEP_W-1:0];
            REG_MAX_SPEED:     cfg_in.max_speed     = csr_bus.data[STEP_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.axis_enabled  <= 1'b0;
         cfg_ff.axis_center   <= RST_AXIS_CENTER;
         cfg_ff.dead_half     <= RST_DEAD_HALF;
         cfg_ff.invert_axis   <= 1'b0;
         cfg_ff.joystick_gain <= RST_JOYSTICK_GAIN;
         cfg_ff.acceleration  <= RST_ACCELERATION;
         cfg_ff.deceleration  <= RST_DECELERATION;
         cfg_ff.max_speed     <= RST_MAX_SPEED;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ rtl/adrc_speed_calc.sv @@
// next-speed logic: dead-zone test, joystick scaling, key ramp and idle decay
module adrc_speed_calc (
   input  adrc_pkg::cfg_type                  cfg,
   input  logic [adrc_pkg::AXIS_W-1:0]        raw_axis,
   input  logic                               key_up,
   input  logic                               key_down,
   input  logic signed [adrc_pkg::SPEED_W-1:0] speed_cur,
   output logic signed [adrc_pkg::SPEED_W-1:0] speed_next,
   output logic                               joystick_active
);
   import adrc_pkg::*;

   logic signed [WIDE_W-1:0]   sample_w;
   logic signed [WIDE_W-1:0]   center_w;
   logic signed [WIDE_W-1:0]   dead_w;
   logic signed [WIDE_W-1:0]   bound_hi;
   logic signed [WIDE_W-1:0]   bound_lo;
   logic signed [AXIS_W:0]     diff;
   logic signed [PROD_W-1:0]   prod;
   logic signed [WIDE_W-1:0]   scaled;
   logic signed [WIDE_W-1:0]   joy_val;
   logic signed [WIDE_W-1:0]   cur_w;
   logic signed [WIDE_W-1:0]   acc_w;
   logic signed [WIDE_W-1:0]   dec_w;
   logic signed [WIDE_W-1:0]   max_w;
   logic                       outside;

   // bounds kept at full precision, no wrap
   assign sample_w = $signed({{(WIDE_W-AXIS_W){1'b0}}, raw_axis});
   assign center_w = $signed({{(WIDE_W-AXIS_W){1'b0}}, cfg.axis_center});
   assign dead_w   = $signed({{(WIDE_W-AXIS_W){1'b0}}, cfg.dead_half});
   assign bound_hi = center_w + dead_w;
   assign bound_lo = center_w - dead_w;
   assign outside  = cfg.axis_enabled && ((sample_w > bound_hi) || (sample_w < bound_lo));

   // arithmetic shift of the product floors toward minus infinity
   assign diff    = $signed({1'b0, raw_axis}) - $signed({1'b0, cfg.axis_center});
   assign prod    = diff * $signed({1'b0, cfg.joystick_gain});
   assign scaled  = prod[SHIFT_W +: WIDE_W];
   assign joy_val = cfg.invert_axis ? -scaled : scaled;

   assign cur_w = {{(WIDE_W-SPEED_W){speed_cur[SPEED_W-1]}}, speed_cur};
   assign acc_w = $signed({{(WIDE_W-STEP_W){1'b0}}, cfg.acceleration});
   assign dec_w = $signed({{(WIDE_W-STEP_W){1'b0}}, cfg.deceleration});
   assign max_w = $signed({{(WIDE_W-STEP_W){1'b0}}, cfg.max_speed});

   always_comb begin
      speed_next      = speed_cur;
      joystick_active = 1'b0;
      if (outside) begin
         speed_next      = sat_speed(joy_val);
         joystick_active = 1'b1;
      end else if (key_up) begin
         // up key wins when both are held
         if (cur_w < max_w) begin
            speed_next = sat_speed(cur_w + acc_w);
         end
      end else if (key_down) begin
         if (cur_w > -max_w) begin
            speed_next = sat_speed(cur_w - acc_w);
         end
      end else begin
         if (cur_w <= -SNAP_LIMIT) begin
            speed_next = sat_speed(cur_w + dec_w);
         end else if (cur_w >= SNAP_LIMIT) begin
            speed_next = sat_speed(cur_w - dec_w);
         end else begin
            speed_next = '0;
         end
      end
   end

endmodule

@@ rtl/axis_deadzone_ramp_conditioner.sv @@
// top level: input stage, speed update with its state, output stage
//
//  channel   dir   payload                                  handshake
//  req_bus   in    raw_axis[15:0], key_up, key_down         valid/ready
//  rsp_bus   out   speed[15:0] signed q4.12, joystick_active valid/ready
//  csr_bus   in    index[2:0], data[15:0]                   valid/ready, always ready
//
// one item per cycle sustained while rsp_bus is not stalled; a taken item
// passes the input register, then the speed logic into the output register,
// before it shows on rsp_bus
// the speed state is updated as an item moves into the output register, so
// the loop from speed_ff through the ramp and decay logic sets the rate
// reset (synchronous) empties both stages, zeroes the speed, loads register defaults
// a stalled rsp_bus holds its item; req_bus still takes one more item into
// the input stage while that stage is empty
module axis_deadzone_ramp_conditioner (
   input  logic        clock,
   input  logic        reset,
   adrc_req_if.sink    req_bus,
   adrc_rsp_if.source  rsp_bus,
   adrc_csr_if.sink    csr_bus
);
   import adrc_pkg::*;

   cfg_type cfg;

   // input stage
   logic                in_valid_ff;
   logic                in_valid_in;
   logic [AXIS_W-1:0]   raw_ff;
   logic                up_ff;
   logic                down_ff;

   // output stage
   logic                      out_valid_ff;
   logic                      out_valid_in;
   logic signed [SPEED_W-1:0] out_speed_ff;
   logic                      out_joy_ff;

   // speed state carried from tick to tick
   logic signed [SPEED_W-1:0] speed_ff;
   logic signed [SPEED_W-1:0] speed_in;
   logic                      joy_in;

   logic req_take;
   logic out_free;
   logic advance;

   adrc_csr_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   adrc_speed_calc u_calc (
      .cfg             (cfg),
      .raw_axis        (raw_ff),
      .key_up          (up_ff),
      .key_down        (down_ff),
      .speed_cur       (speed_ff),
      .speed_next      (speed_in),
      .joystick_active (joy_in)
   );

   // output stage frees up when empty or being drained this cycle
   assign out_free      = !out_valid_ff || rsp_bus.ready;
   assign advance       = in_valid_ff && out_free;
   assign req_bus.ready = !in_valid_ff || out_free;
   assign req_take      = req_bus.valid && req_bus.ready;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         speed_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            speed_ff <= speed_in;
         end
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         raw_ff  <= req_bus.raw_axis;
         up_ff   <= req_bus.key_up;
         down_ff <= req_bus.key_down;
      end
      if (advance) begin
         out_speed_ff <= speed_in;
         out_joy_ff   <= joy_in;
      end
   end

   assign rsp_bus.valid           = out_valid_ff;
   assign rsp_bus.speed           = out_speed_ff;
   assign rsp_bus.joystick_active = out_joy_ff;

endmodule

@@ rtl/adrc_checker.sv @@
// port-level checks for the conditioner, bound to the top level
module adrc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [adrc_pkg::SPEED_W-1:0]  rsp_speed,
   input logic                          rsp_joystick_active
);
   import adrc_pkg::*;

   logic req_take;
   assign req_take = req_valid && req_ready;

   // reset empties the output stage
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // a fresh result comes from an item taken at req_bus into the input register
   a_rise_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_take, 2))
      else $error("result without a matching item");

   // with the output stage empty the input side never stalls
   a_no_bubble_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req not ready while output stage empty");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_speed) && $stable(rsp_joystick_active))
      else $error("stalled result changed");

endmodule

bind axis_deadzone_ramp_conditioner adrc_checker u_adrc_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_bus.valid),
   .req_ready           (req_bus.ready),
   .rsp_valid           (rsp_bus.valid),
   .rsp_ready           (rsp_bus.ready),
   .rsp_speed           (rsp_bus.speed),
   .rsp_joystick_active (rsp_bus.joystick_active)
);
